/* sv/ltcd_pkg.sv */
// Package for the line table crossing and distance block.
// Holds field widths, op codes and the distance sentinel; no dependencies.
package ltcd_pkg;
    localparam int MaxLinesDefault = 8;
    localparam int SlopeW = 24;
    localparam int InterceptW = 32;
    localparam int CoordW = 21;
    localparam int DistW = 25;
    localparam logic [DistW-1:0] DistSentinel = 25'd25600000;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CROSS = 2'd1,
        OP_DIST  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Query broadcast handed from cell to cell.
    typedef struct packed {
        logic                     valid;
        op_t                      op;
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
    } query_t;
endpackage

/* sv/ltcd_cell.sv */
// One line cell: stores a slope and intercept, computes the two scaled residuals
// of a query in the cycle after it arrives and passes the query on. Uses ltcd_pkg.
module ltcd_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic signed [ltcd_pkg::SlopeW-1:0] wr_slope,
    input  logic signed [ltcd_pkg::InterceptW-1:0] wr_intercept,
    input  ltcd_pkg::query_t                   q_in,
    output ltcd_pkg::query_t                   q_out,
    output logic signed [ltcd_pkg::SlopeW-1:0] slope,
    output logic signed [47:0]                 res_s,
    output logic signed [47:0]                 res_e
);
    import ltcd_pkg::*;

    logic signed [SlopeW-1:0]     slope_reg;
    logic signed [InterceptW-1:0] icpt_reg;
    query_t                       q_reg;
    logic signed [47:0]           res_s_reg, res_e_reg;

    // Residual m*x + 4096*(b - y); at most about 2^45 in magnitude.
    function automatic logic signed [47:0] resid(input logic signed [SlopeW-1:0] m,
        input logic signed [InterceptW-1:0] b, input logic signed [CoordW-1:0] x,
        input logic signed [CoordW-1:0] y);
        logic signed [47:0] p;
        p = 48'(m) * 48'(x);
        return p + (48'(b) <<< 12) - (48'(y) <<< 12);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slope_reg <= wr_slope;
            icpt_reg  <= wr_intercept;
        end
        res_s_reg <= resid(slope_reg, icpt_reg, q_in.sx, q_in.sy);
        res_e_reg <= resid(slope_reg, icpt_reg, q_in.ex, q_in.ey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else
            q_reg <= q_in;
    end

    assign q_out = q_reg;
    assign slope = slope_reg;
    assign res_s = res_s_reg;
    assign res_e = res_e_reg;
endmodule

/* sv/ltcd_dist.sv */
// Shared distance unit: the largest D up to the sentinel with D*D*S <= N*N,
// found one result bit per step; the bit steps use shifts and adds only. Uses ltcd_pkg.
module ltcd_dist (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [46:0]                        n_abs,
    input  logic signed [ltcd_pkg::SlopeW-1:0] m,
    output logic                               done,
    output logic [ltcd_pkg::DistW-1:0]         d
);
    import ltcd_pkg::*;

    // Restoring search, one result bit per step. The remainder R = N^2 - D^2*S
    // and the product T = S*D are kept, so trying D + 2^k only needs the test
    // ((2*T + (S << k)) << k) <= R. N^2 is built from three 24-bit products.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_N0   = 6'b000010,
        S_N1   = 6'b000100,
        S_N2   = 6'b001000,
        S_TRY  = 6'b010000,
        S_CMP  = 6'b100000
    } dstate_t;

    dstate_t            st_reg;
    logic [4:0]         bit_reg;
    logic [DistW-1:0]   d_reg;
    logic [DistW-1:0]   trial_reg;
    logic [48:0]        s_reg;
    logic [93:0]        rem_reg;
    logic [73:0]        t_reg;
    logic [73:0]        sk_reg;
    logic [99:0]        delta_reg;
    logic [46:0]        n_reg;
    logic               done_reg;
    logic [SlopeW-1:0]  mabs;

    assign mabs = m[SlopeW-1] ? SlopeW'(-m) : SlopeW'(m);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg   <= n_abs;
                        s_reg   <= 49'(mabs) * 49'(mabs) + (49'd1 << 24);
                        d_reg   <= '0;
                        t_reg   <= '0;
                        bit_reg <= 5'(DistW - 1);
                        st_reg  <= S_N0;
                    end
                end
                S_N0:
                begin
                    rem_reg <= 94'(48'(n_reg[23:0]) * 48'(n_reg[23:0]));
                    st_reg  <= S_N1;
                end
                S_N1:
                begin
                    rem_reg <= rem_reg
                             + (94'(48'(n_reg[46:24]) * 48'(n_reg[23:0])) << 25);
                    st_reg  <= S_N2;
                end
                S_N2:
                begin
                    rem_reg <= rem_reg
                             + (94'(48'(n_reg[46:24]) * 48'(n_reg[46:24])) << 48);
                    st_reg  <= S_TRY;
                end
                S_TRY:
                begin
                    trial_reg <= d_reg | (DistW'(1) << bit_reg);
                    sk_reg    <= 74'(s_reg) << bit_reg;
                    delta_reg <= ((100'(t_reg) << 1) + (100'(s_reg) << bit_reg))
                                 << bit_reg;
                    st_reg    <= S_CMP;
                end
                S_CMP:
                begin
                    if (delta_reg <= 100'(rem_reg) && trial_reg <= DistSentinel)
                    begin
                        rem_reg <= rem_reg - 94'(delta_reg);
                        t_reg   <= t_reg + sk_reg;
                        d_reg   <= trial_reg;
                    end
                    if (bit_reg == 5'd0)
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 5'd1;
                        st_reg  <= S_TRY;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign d    = d_reg;
endmodule

/* sv/line_table_crossing_and_distance.sv */
// Top level of the line table crossing and distance block.
// Instantiates a chain of ltcd_cell and one shared ltcd_dist; uses ltcd_pkg.
//
//  channel | group                | payload
//  --------+----------------------+------------------------------------------
//  input   | s_tvalid/s_tready    | s_tdata: op, slope, intercept, sx, sy, ex, ey
//  output  | m_tvalid/m_tready    | m_tdata: count, mask, any, index, dist,
//          |                      |          full, lines_stored
//
// Steps: an add or an unused op goes straight to the output state; a crossing
// query walks down the whole chain of cells; a distance query then runs the
// shared distance unit once for each stored line (a start, the offset squared
// in S_N0, S_N1 and S_N2, a trial and a compare for each of 25 result bits,
// and collecting the answer). One request is in flight at a time.
// Reset clears the line count and control; stored lines are undefined until
// written. A finished result sits in the output register until taken; the next
// request may be accepted meanwhile, and its own result waits until it is free.
module line_table_crossing_and_distance #(
    parameter int MAX_LINES = ltcd_pkg::MaxLinesDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: op[1:0], line_slope[25:2], line_intercept[57:26],
    // start_x[78:58], start_y[99:79], end_x[120:100], end_y[141:121], zeros
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: crossing_count[3:0], crossing_mask[11:4],
    // any_crossing[12], nearest_index[15:13], nearest_distance[40:16],
    // table_full[41], lines_stored[45:42], zeros
    output logic [47:0]  m_tdata
);
    import ltcd_pkg::*;

    localparam int IdxW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CntW = $clog2(MAX_LINES + 1);

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_WALK  = 5'b00010,
        T_DSTRT = 5'b00100,
        T_DWAIT = 5'b01000,
        T_OUT   = 5'b10000
    } tstate_t;

    tstate_t              st_reg;
    logic [CntW-1:0]      count_reg;
    logic [CntW:0]        step_reg;
    op_t                  op_reg;
    logic [3:0]           ccount_reg;
    logic                 any_reg;
    logic [7:0]           mask_reg;
    logic [2:0]           idx_reg;
    logic [DistW-1:0]     dist_reg;
    logic                 full_reg;
    logic [47:0]          out_reg;
    logic                 out_valid_reg;
    logic [IdxW-1:0]      dline_reg;
    logic [46:0]          dn_reg [MAX_LINES];
    logic signed [SlopeW-1:0] dm_reg [MAX_LINES];

    query_t               q [MAX_LINES+1];
    logic signed [SlopeW-1:0] slopes [MAX_LINES];
    logic signed [47:0]   rs [MAX_LINES];
    logic signed [47:0]   re [MAX_LINES];

    logic                 acc;
    op_t                  in_op;
    query_t               q_head;
    logic                 dstart;
    logic                 ddone;
    logic [DistW-1:0]     dval;
    logic                 out_load;

    assign in_op    = op_t'(s_tdata[1:0]);
    assign s_tready = (st_reg == T_IDLE);
    assign acc      = s_tvalid && s_tready;
    // The finished result moves into the output register once it is free.
    assign out_load = (st_reg == T_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        q_head.valid = acc && (in_op == OP_CROSS || in_op == OP_DIST);
        q_head.op    = in_op;
        q_head.sx    = s_tdata[78:58];
        q_head.sy    = s_tdata[99:79];
        q_head.ex    = s_tdata[120:100];
        q_head.ey    = s_tdata[141:121];
    end
    assign q[0] = q_head;

    // Each cell sees the query in the cycle after its left neighbor does; cell i's
    // residuals come out with q[i+1].valid.
    for (genvar i = 0; i < MAX_LINES; i++)
    begin : g_cell
        ltcd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .wr_en        (acc && in_op == OP_ADD && count_reg == CntW'(i)),
            .wr_slope     (s_tdata[25:2]),
            .wr_intercept (s_tdata[57:26]),
            .q_in         (q[i]),
            .q_out        (q[i+1]),
            .slope        (slopes[i]),
            .res_s        (rs[i]),
            .res_e        (re[i])
        );
    end

    ltcd_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .n_abs (dn_reg[dline_reg]),
        .m     (dm_reg[dline_reg]),
        .done  (ddone),
        .d     (dval)
    );
    assign dstart = (st_reg == T_DSTRT);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LINES; i++)
        begin
            if (q[i+1].valid)
            begin
                dn_reg[i] <= 47'(rs[i][47] ? -rs[i] : rs[i]);
                dm_reg[i] <= slopes[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= T_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
            dline_reg     <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (st_reg)
                T_IDLE:
                begin
                    if (acc)
                    begin
                        op_reg     <= in_op;
                        ccount_reg <= '0;
                        any_reg    <= 1'b0;
                        mask_reg   <= '0;
                        idx_reg    <= '0;
                        dist_reg   <= (in_op == OP_DIST) ? DistSentinel : '0;
                        full_reg   <= 1'b0;
                        step_reg   <= '0;
                        dline_reg  <= '0;
                        if (in_op == OP_ADD)
                        begin
                            if (count_reg == CntW'(MAX_LINES))
                                full_reg <= 1'b1;
                            else
                                count_reg <= count_reg + 1'b1;
                            st_reg <= T_OUT;
                        end
                        else if (in_op == OP_CROSS || in_op == OP_DIST)
                            st_reg <= T_WALK;
                        else
                            st_reg <= T_OUT;
                    end
                end
                T_WALK:
                begin
                    // step k: residuals of cell k are visible now
                    if (step_reg < (CntW+1)'(count_reg) && op_reg == OP_CROSS
                        && ((rs[step_reg[IdxW-1:0]] > 0) != (re[step_reg[IdxW-1:0]] > 0)))
                    begin
                        ccount_reg <= ccount_reg + 4'd1;
                        any_reg    <= 1'b1;
                        if (step_reg < 8)
                            mask_reg[step_reg[2:0]] <= 1'b1;
                    end
                    if (step_reg == (CntW+1)'(MAX_LINES - 1))
                        st_reg <= (op_reg == OP_DIST && count_reg != 0) ? T_DSTRT : T_OUT;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                T_DSTRT: st_reg <= T_DWAIT;
                T_DWAIT:
                begin
                    if (ddone)
                    begin
                        if (dval < dist_reg)
                        begin
                            dist_reg <= dval;
                            idx_reg  <= 3'(dline_reg);
                        end
                        if ((CntW+1)'(dline_reg) + 1'b1 >= (CntW+1)'(count_reg))
                            st_reg <= T_OUT;
                        else
                        begin
                            dline_reg <= dline_reg + 1'b1;
                            st_reg    <= T_DSTRT;
                        end
                    end
                end
                T_OUT:
                begin
                    if (out_load)
                        st_reg <= T_IDLE;
                end
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= {2'b00, 4'(count_reg), full_reg, dist_reg, idx_reg,
                        any_reg, mask_reg, ccount_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule

/* sv/ltcd_checker.sv */
// Port-level checker for line_table_crossing_and_distance, bound to the top.
// Uses only the top level's ports.
module ltcd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_any: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] != 4'd0) |-> m_tdata[12])
        else $error("any flag disagrees with count");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[41] |-> m_tdata[3:0] == 4'd0)
        else $error("table full flag with crossings");
endmodule

bind line_table_crossing_and_distance ltcd_checker u_ltcd_checker (.*);
